// ===== sv/utf8v_pkg.sv =====
package utf8v_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned CfgIdxW  = 2;

  // status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StBadLead    = 3'd1;
  localparam logic [2:0] StBadTrail   = 3'd2;
  localparam logic [2:0] StOverlong   = 3'd3;
  localparam logic [2:0] StTooBig     = 3'd4;
  localparam logic [2:0] StSurrogate  = 3'd5;
  localparam logic [2:0] StRestricted = 3'd6;
  localparam logic [2:0] StIncomplete = 3'd7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxCodepoint  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRestrictedLow = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRestrictedHi  = 2'd2;

  localparam logic [CpWidth-1:0] MaxCodepointRst  = 21'h10FFFF;
  localparam logic [CpWidth-1:0] RestrictedLowRst = 21'h1FFFFF;
  localparam logic [CpWidth-1:0] RestrictedHiRst  = 21'h000000;

  // shortest-form limits and the surrogate range
  localparam logic [CpWidth-1:0] Min2Byte   = 21'h00080;
  localparam logic [CpWidth-1:0] Min3Byte   = 21'h00800;
  localparam logic [CpWidth-1:0] Min4Byte   = 21'h10000;
  localparam logic [CpWidth-1:0] SurrLow    = 21'h0D800;
  localparam logic [CpWidth-1:0] SurrHigh   = 21'h0DFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [2:0]         byte_width;
    logic [2:0]         status;
    logic               text_done;
  } out_word_t;

  typedef struct packed {
    logic [CpWidth-1:0] value_acc;
    logic [1:0]         bytes_left;
    logic [2:0]         seq_width;
    logic               halted;
  } dec_state_t;

  typedef struct packed {
    logic [CpWidth-1:0] max_codepoint;
    logic [CpWidth-1:0] restricted_low;
    logic [CpWidth-1:0] restricted_high;
  } cfg_t;

endpackage

// ===== sv/utf8_stream_validator.sv =====
// UTF-8 stream validator: takes one byte word per cycle on the input channel
// and returns one result word for each finished, failed or cut-short
// character, carrying the code point, the sequence width, a status code and
// a flag set on a result whose byte carried end_of_text. Sustained rate is
// one byte per clock while the output is not stalled; a byte accepted into
// the input register leaves it only when the output register is free, and
// its result, if any, is then loaded into the output register.
// The decode step between the two registers is combinational; it only
// shifts in six bits and compares against a few constants and the
// configuration values.
// After any error the block drops bytes without results until a byte with
// end_of_text set, which resets the decode state. Configuration writes are
// always accepted and should be made only while no text is in flight.
module utf8_stream_validator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  utf8v_pkg::in_word_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output utf8v_pkg::out_word_t          out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utf8v_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [utf8v_pkg::CpWidth-1:0] cfg_data_i
);

  utf8v_pkg::cfg_t       cfg;

  // input register
  logic                  s1_valid_q;
  utf8v_pkg::in_word_t   s1_word_q;

  // running decode state
  utf8v_pkg::dec_state_t state_q;
  utf8v_pkg::dec_state_t state_d;

  // output register
  logic                  out_valid_q;
  logic                  out_valid_d;
  utf8v_pkg::out_word_t  out_word_q;

  logic                  res_valid;
  utf8v_pkg::out_word_t  res_word;
  logic                  out_free;
  logic                  s1_adv;

  utf8v_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  utf8v_step u_step (
    .state_i     (state_q),
    .word_i      (s1_word_q),
    .cfg_i       (cfg),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  // the output slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  // a byte leaves the input register only if its result has a place to go
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  assign out_valid_d = s1_adv ? res_valid : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q <= in_data_i;
    end
    if (s1_adv && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

// ===== sv/utf8v_cfg_regs.sv =====
module utf8v_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [utf8v_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [utf8v_pkg::CpWidth-1:0]       cfg_data_i,
  output utf8v_pkg::cfg_t                     cfg_o
);

  utf8v_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_codepoint   <= utf8v_pkg::MaxCodepointRst;
      cfg_q.restricted_low  <= utf8v_pkg::RestrictedLowRst;
      cfg_q.restricted_high <= utf8v_pkg::RestrictedHiRst;
    end else if (cfg_valid_i) begin
      // unknown indexes are dropped
      if (cfg_index_i == utf8v_pkg::CfgMaxCodepoint) begin
        cfg_q.max_codepoint <= cfg_data_i;
      end
      if (cfg_index_i == utf8v_pkg::CfgRestrictedLow) begin
        cfg_q.restricted_low <= cfg_data_i;
      end
      if (cfg_index_i == utf8v_pkg::CfgRestrictedHi) begin
        cfg_q.restricted_high <= cfg_data_i;
      end
    end
  end

endmodule

// ===== sv/utf8v_step.sv =====
module utf8v_step (
  input  utf8v_pkg::dec_state_t state_i,
  input  utf8v_pkg::in_word_t   word_i,
  input  utf8v_pkg::cfg_t       cfg_i,
  output utf8v_pkg::dec_state_t state_o,
  output logic                  res_valid_o,
  output utf8v_pkg::out_word_t  res_o
);

  logic [7:0]                  b;
  logic                        eot;
  logic [utf8v_pkg::CpWidth-1:0] acc;
  logic [1:0]                  left;
  logic [2:0]                  width;
  logic [2:0]                  chk;

  assign b   = word_i.data_byte;
  assign eot = word_i.end_of_text;

  // checks on a finished sequence, first failure wins
  always_comb begin
    priority if ((acc < utf8v_pkg::Min2Byte && width >= 3'd2) ||
                 (acc < utf8v_pkg::Min3Byte && width >= 3'd3) ||
                 (acc < utf8v_pkg::Min4Byte && width >= 3'd4)) begin
      chk = utf8v_pkg::StOverlong;
    end else if (acc > cfg_i.max_codepoint) begin
      chk = utf8v_pkg::StTooBig;
    end else if (acc >= utf8v_pkg::SurrLow && acc <= utf8v_pkg::SurrHigh) begin
      chk = utf8v_pkg::StSurrogate;
    end else if (acc >= cfg_i.restricted_low && acc <= cfg_i.restricted_high) begin
      chk = utf8v_pkg::StRestricted;
    end else begin
      chk = utf8v_pkg::StOk;
    end
  end

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    acc         = state_i.value_acc;
    left        = state_i.bytes_left;
    width       = state_i.seq_width;

    if (state_i.halted) begin
      if (eot) begin
        state_o = '0;
      end
    end else if (state_i.bytes_left == 2'd0 && b[7:6] == 2'b10
                 || state_i.bytes_left == 2'd0 && b[7:3] == 5'b11111) begin
      // bad lead byte
      res_valid_o      = 1'b1;
      res_o.code_point = '0;
      res_o.byte_width = 3'd1;
      res_o.status     = utf8v_pkg::StBadLead;
      res_o.text_done  = eot;
      state_o          = '0;
      state_o.halted   = !eot;
    end else if (state_i.bytes_left != 2'd0 && b[7:6] != 2'b10) begin
      // bad trail byte
      res_valid_o      = 1'b1;
      res_o.code_point = state_i.value_acc;
      res_o.byte_width = state_i.seq_width;
      res_o.status     = utf8v_pkg::StBadTrail;
      res_o.text_done  = eot;
      state_o          = '0;
      state_o.halted   = !eot;
    end else begin
      if (state_i.bytes_left == 2'd0) begin
        priority if (!b[7]) begin
          acc = {13'd0, b};       width = 3'd1; left = 2'd0;
        end else if (!b[5]) begin
          acc = {16'd0, b[4:0]};  width = 3'd2; left = 2'd1;
        end else if (!b[4]) begin
          acc = {17'd0, b[3:0]};  width = 3'd3; left = 2'd2;
        end else begin
          acc = {18'd0, b[2:0]};  width = 3'd4; left = 2'd3;
        end
      end else begin
        acc  = {state_i.value_acc[utf8v_pkg::CpWidth-7:0], b[5:0]};
        left = state_i.bytes_left - 2'd1;
      end

      if (left != 2'd0) begin
        if (eot) begin
          res_valid_o      = 1'b1;
          res_o.code_point = acc;
          res_o.byte_width = width;
          res_o.status     = utf8v_pkg::StIncomplete;
          res_o.text_done  = 1'b1;
          state_o          = '0;
        end else begin
          state_o.value_acc  = acc;
          state_o.bytes_left = left;
          state_o.seq_width  = width;
        end
      end else begin
        res_valid_o      = 1'b1;
        res_o.code_point = acc;
        res_o.byte_width = width;
        res_o.status     = chk;
        res_o.text_done  = eot;
        state_o          = '0;
        state_o.halted   = (chk != utf8v_pkg::StOk) && !eot;
      end
    end
  end

endmodule
